// ----- rtl/rtcal_pkg.sv -----
// Package for the real-time clock and calendar with alarm.
// Holds beat types, command and register codes and the month-length table.
// No dependencies.
package rtcal_pkg;

    // Input commands.
    localparam logic CMD_TICK = 1'b0;
    localparam logic CMD_LOAD = 1'b1;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned CFG_DATA_W = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_HOUR   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALARM_MINUTE = 2'd2;

    // Roll-over limits.
    localparam logic [6:0] SEC_LIMIT   = 7'd60;
    localparam logic [6:0] MIN_LIMIT   = 7'd60;
    localparam logic [5:0] HOUR_LIMIT  = 6'd24;
    localparam logic [4:0] MONTH_LAST  = 5'd12;
    localparam logic [3:0] MONTH_FEB   = 4'd2;
    localparam logic [4:0] FEB_LEAP    = 5'd29;

    // Reciprocal of 100 for a 16-bit year: floor(y / 100) = (y * RECIP_100) >> RECIP_SHIFT.
    localparam logic [16:0] RECIP_100   = 17'd83887;
    localparam int unsigned RECIP_SHIFT = 23;

    // Reset values of the kept time.
    localparam logic [15:0] RESET_YEAR  = 16'd2000;
    localparam logic [3:0]  RESET_MONTH = 4'd1;
    localparam logic [4:0]  RESET_DAY   = 5'd1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
        logic [4:0]  load_hour;
        logic [5:0]  load_minute;
        logic [5:0]  load_second;
    } t_in_beat;

    typedef struct packed {
        logic [15:0] out_year;
        logic [3:0]  out_month;
        logic [4:0]  out_day;
        logic [4:0]  out_hour;
        logic [5:0]  out_minute;
        logic [5:0]  out_second;
        logic        alarm_hit;
    } t_out_beat;

    typedef struct packed {
        logic [15:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic [4:0]  hour;
        logic [5:0]  minute;
        logic [5:0]  second;
    } t_time;

    // Days in a month for a common year; codes outside 1..12 give 31.
    function automatic logic [4:0] month_len(input logic [3:0] month);
        logic [4:0] days;
        unique case (month)
            4'd2:                      days = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   days = 5'd30;
            default:                   days = 5'd31;
        endcase
        return days;
    endfunction

endpackage

// ----- rtl/rtc_calendar_with_alarm_top.sv -----
// Real-time clock and calendar with a daily alarm: top level.
// The result beat of an accepted input beat is registered and appears in the next cycle.
// Throughput: one beat per cycle unless the result side stalls; the kept-time
// registers feed the next-time logic, slowest on the year multiply of the leap test.
// Reset (synchronous, active low) sets 2000-01-01 00:00:00, clears the alarm
// registers and empties the result register. Depends on rtcal_pkg, rtcal_advance.
module rtc_calendar_with_alarm_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [rtcal_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rtcal_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    // Input channel.
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  rtcal_pkg::t_in_beat                 i_in_beat,
    // Result channel.
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output rtcal_pkg::t_out_beat                o_out_beat
);

    // Kept time. These registers are the calendar state and change only
    // when an input beat is accepted.
    rtcal_pkg::t_time r_time;
    rtcal_pkg::t_time n_time;

    // Alarm configuration.
    logic       r_alarm_enable;
    logic [4:0] r_alarm_hour;
    logic [5:0] r_alarm_minute;

    // Result register. It holds one finished beat; a new input beat is taken
    // whenever this register is empty or is being drained in the same cycle.
    logic                 r_out_valid;
    rtcal_pkg::t_out_beat r_out_beat;
    rtcal_pkg::t_out_beat n_out_beat;

    logic in_accept;

    assign o_in_stall = r_out_valid && i_out_stall;
    assign in_accept  = i_in_valid && !o_in_stall;

    rtcal_advance u_advance (
        .i_beat (i_in_beat),
        .i_time (r_time),
        .o_time (n_time)
    );

    // The result carries the time after this beat, and the alarm compares
    // against that same time, for loads as well as for ticks.
    always_comb begin
        n_out_beat.out_year   = n_time.year;
        n_out_beat.out_month  = n_time.month;
        n_out_beat.out_day    = n_time.day;
        n_out_beat.out_hour   = n_time.hour;
        n_out_beat.out_minute = n_time.minute;
        n_out_beat.out_second = n_time.second;
        n_out_beat.alarm_hit  = r_alarm_enable
                              && (n_time.hour == r_alarm_hour)
                              && (n_time.minute == r_alarm_minute)
                              && (n_time.second == 6'd0);
    end

    // Calendar state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time.year   <= rtcal_pkg::RESET_YEAR;
            r_time.month  <= rtcal_pkg::RESET_MONTH;
            r_time.day    <= rtcal_pkg::RESET_DAY;
            r_time.hour   <= 5'd0;
            r_time.minute <= 6'd0;
            r_time.second <= 6'd0;
        end else if (in_accept) begin
            r_time <= n_time;
        end
    end

    // Configuration writes; an index beyond the register list is ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alarm_enable <= 1'b0;
            r_alarm_hour   <= 5'd0;
            r_alarm_minute <= 6'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                rtcal_pkg::CFG_ALARM_ENABLE: r_alarm_enable <= i_cfg_data[0];
                rtcal_pkg::CFG_ALARM_HOUR:   r_alarm_hour   <= i_cfg_data[4:0];
                rtcal_pkg::CFG_ALARM_MINUTE: r_alarm_minute <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Result valid: set by an accepted beat, cleared once the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload needs no reset; it only loads with an accepted beat.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_out_beat <= n_out_beat;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out_beat;

endmodule

// ----- rtl/rtcal_advance.sv -----
// Next-time logic of the calendar: a one-second tick with full roll-over,
// or a load of the given fields. Depends on rtcal_pkg.
module rtcal_advance (
    input  rtcal_pkg::t_in_beat i_beat,
    input  rtcal_pkg::t_time    i_time,
    output rtcal_pkg::t_time    o_time
);

    logic [32:0] year_prod;
    logic [9:0]  year_q100;
    logic [16:0] year_back;
    logic        div100;
    logic        div400;
    logic        leap;
    logic [4:0]  mon_days;
    logic [6:0]  sec_inc;
    logic [6:0]  min_inc;
    logic [5:0]  hour_inc;
    logic [5:0]  day_inc;
    logic [4:0]  month_inc;
    rtcal_pkg::t_time tick_time;

    // Leap year test. The quotient by 100 comes from a reciprocal multiply,
    // checked by multiplying back with shifts and adds.
    assign year_prod = {1'b0, i_time.year} * {16'd0, rtcal_pkg::RECIP_100};
    assign year_q100 = year_prod[32:rtcal_pkg::RECIP_SHIFT];
    assign year_back = {1'b0, year_q100, 6'd0} + {2'b0, year_q100, 5'd0}
                     + {5'd0, year_q100, 2'd0};
    assign div100    = (year_back == {1'b0, i_time.year});
    assign div400    = div100 && (year_q100[1:0] == 2'd0);
    assign leap      = div400 || (!div100 && (i_time.year[1:0] == 2'd0));

    always_comb begin
        if (i_time.month == rtcal_pkg::MONTH_FEB && leap) begin
            mon_days = rtcal_pkg::FEB_LEAP;
        end else begin
            mon_days = rtcal_pkg::month_len(i_time.month);
        end
    end

    assign sec_inc   = {1'b0, i_time.second} + 7'd1;
    assign min_inc   = {1'b0, i_time.minute} + 7'd1;
    assign hour_inc  = {1'b0, i_time.hour} + 6'd1;
    assign day_inc   = {1'b0, i_time.day} + 6'd1;
    assign month_inc = {1'b0, i_time.month} + 5'd1;

    always_comb begin
        tick_time = i_time;
        if (sec_inc < rtcal_pkg::SEC_LIMIT) begin
            tick_time.second = sec_inc[5:0];
        end else begin
            tick_time.second = 6'd0;
            if (min_inc < rtcal_pkg::MIN_LIMIT) begin
                tick_time.minute = min_inc[5:0];
            end else begin
                tick_time.minute = 6'd0;
                if (hour_inc < rtcal_pkg::HOUR_LIMIT) begin
                    tick_time.hour = hour_inc[4:0];
                end else begin
                    tick_time.hour = 5'd0;
                    if (day_inc <= {1'b0, mon_days}) begin
                        tick_time.day = day_inc[4:0];
                    end else begin
                        tick_time.day = 5'd1;
                        if (month_inc <= rtcal_pkg::MONTH_LAST) begin
                            tick_time.month = month_inc[3:0];
                        end else begin
                            tick_time.month = 4'd1;
                            tick_time.year  = i_time.year + 16'd1;
                        end
                    end
                end
            end
        end
    end

    always_comb begin
        if (i_beat.cmd == rtcal_pkg::CMD_LOAD) begin
            o_time.year   = i_beat.load_year;
            o_time.month  = i_beat.load_month;
            o_time.day    = i_beat.load_day;
            o_time.hour   = i_beat.load_hour;
            o_time.minute = i_beat.load_minute;
            o_time.second = i_beat.load_second;
        end else begin
            o_time = tick_time;
        end
    end

endmodule

// ----- bench/rtcal_checker.sv -----
// Checker for the real-time clock and calendar with alarm.
// Watches the register port and both channels, keeps its own copy of the calendar state
// and compares every result beat with its prediction. Depends on rtcal_pkg.
`timescale 1ns / 100ps

module rtcal_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [rtcal_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rtcal_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  rtcal_pkg::t_in_beat              i_in_beat,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  rtcal_pkg::t_out_beat             i_out_beat,
    output int                               o_fails,
    output int                               o_waiting
);

    localparam int unsigned SECS_PER_MIN    = 60;
    localparam int unsigned MINS_PER_HOUR   = 60;
    localparam int unsigned HOURS_PER_DAY   = 24;
    localparam int unsigned MONTHS_PER_YEAR = 12;
    localparam int unsigned MAX_SHOWN       = 10;

    rtcal_pkg::t_time     clock_now;
    logic                 alarm_on;
    logic [4:0]           alarm_hour;
    logic [5:0]           alarm_minute;
    rtcal_pkg::t_out_beat due_results[$];
    int                   fail_cnt = 0;
    int                   due_cnt = 0;

    assign o_fails   = fail_cnt;
    assign o_waiting = due_cnt;

    function automatic bit leap_year(input logic [15:0] yr);
        if (yr % 400 == 0) return 1'b1;
        if (yr % 100 == 0) return 1'b0;
        return (yr % 4 == 0);
    endfunction

    // Month codes outside 1..12 count as 31-day months.
    function automatic int unsigned month_days(input logic [3:0] mo, input logic [15:0] yr);
        case (mo)
            4'd2:                    return leap_year(yr) ? 29 : 28;
            4'd4, 4'd6, 4'd9, 4'd11: return 30;
            default:                 return 31;
        endcase
    endfunction

    // Each counter is bumped at full precision, so loaded out-of-range values roll too.
    function automatic void tick_second();
        int unsigned v;
        v = clock_now.second + 1;
        if (v < SECS_PER_MIN) begin
            clock_now.second = 6'(v);
            return;
        end
        clock_now.second = '0;
        v = clock_now.minute + 1;
        if (v < MINS_PER_HOUR) begin
            clock_now.minute = 6'(v);
            return;
        end
        clock_now.minute = '0;
        v = clock_now.hour + 1;
        if (v < HOURS_PER_DAY) begin
            clock_now.hour = 5'(v);
            return;
        end
        clock_now.hour = '0;
        v = clock_now.day + 1;
        if (v <= month_days(clock_now.month, clock_now.year)) begin
            clock_now.day = 5'(v);
            return;
        end
        clock_now.day = 5'd1;
        v = clock_now.month + 1;
        if (v <= MONTHS_PER_YEAR) begin
            clock_now.month = 4'(v);
            return;
        end
        clock_now.month = 4'd1;
        clock_now.year  = clock_now.year + 16'd1;
    endfunction

    function automatic rtcal_pkg::t_out_beat apply_beat(input rtcal_pkg::t_in_beat b);
        rtcal_pkg::t_out_beat r;
        if (b.cmd == rtcal_pkg::CMD_LOAD) begin
            clock_now.year   = b.load_year;
            clock_now.month  = b.load_month;
            clock_now.day    = b.load_day;
            clock_now.hour   = b.load_hour;
            clock_now.minute = b.load_minute;
            clock_now.second = b.load_second;
        end else begin
            tick_second();
        end
        r.out_year   = clock_now.year;
        r.out_month  = clock_now.month;
        r.out_day    = clock_now.day;
        r.out_hour   = clock_now.hour;
        r.out_minute = clock_now.minute;
        r.out_second = clock_now.second;
        r.alarm_hit  = alarm_on && clock_now.hour == alarm_hour &&
                       clock_now.minute == alarm_minute && clock_now.second == 6'd0;
        return r;
    endfunction

    task automatic flag(input string why, input rtcal_pkg::t_out_beat want,
                        input rtcal_pkg::t_out_beat got);
        fail_cnt++;
        if (fail_cnt <= MAX_SHOWN)
            $display({"%0t: %s: expected %0d-%0d-%0d %0d:%0d:%0d alarm %b, ",
                      "got %0d-%0d-%0d %0d:%0d:%0d alarm %b"},
                     $time, why,
                     want.out_year, want.out_month, want.out_day,
                     want.out_hour, want.out_minute, want.out_second, want.alarm_hit,
                     got.out_year, got.out_month, got.out_day,
                     got.out_hour, got.out_minute, got.out_second, got.alarm_hit);
    endtask

    always @(posedge i_clk) begin : watch
        rtcal_pkg::t_out_beat want;
        if (!i_rst_n) begin
            clock_now    = '{year: 16'd2000, month: 4'd1, day: 5'd1,
                             hour: 5'd0, minute: 6'd0, second: 6'd0};
            alarm_on     = 1'b0;
            alarm_hour   = '0;
            alarm_minute = '0;
            due_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rtcal_pkg::CFG_ALARM_ENABLE: alarm_on     = i_cfg_data[0];
                    rtcal_pkg::CFG_ALARM_HOUR:   alarm_hour   = i_cfg_data[4:0];
                    rtcal_pkg::CFG_ALARM_MINUTE: alarm_minute = i_cfg_data[5:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    flag("result beat with nothing expected", '0, i_out_beat);
                end else begin
                    want = due_results.pop_front();
                    if (i_out_beat !== want)
                        flag("result mismatch", want, i_out_beat);
                end
            end
            if (i_in_valid && !i_in_stall)
                due_results.push_back(apply_beat(i_in_beat));
        end
        due_cnt = due_results.size();
    end

endmodule

// ----- bench/tb_rtc_calendar_with_alarm_top.sv -----
// Testbench top for the real-time clock and calendar with alarm.
// Makes clock, reset, register writes and input beats and gives the verdict;
// rtcal_checker predicts and compares. Depends on rtcal_pkg, rtcal_checker and the RTL.
`timescale 1ns / 100ps

module tb_rtc_calendar_with_alarm_top;

    // Index past the end of the register list; writes to it must change nothing.
    localparam logic [rtcal_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int unsigned BEATS_PER_PHASE = 100;
    localparam int unsigned N_PHASES        = 8;
    localparam int unsigned CALM_PHASE      = 4;
    localparam int unsigned IDLE_PCT        = 12;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             cfg_we = 1'b0;
    logic [rtcal_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [rtcal_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    rtcal_pkg::t_in_beat              in_beat = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    rtcal_pkg::t_out_beat             out_beat;
    int                               fails;
    int                               waiting;

    // While calm is set neither side idles, giving one long back-to-back stretch.
    bit                    calm = 1'b0;
    int unsigned           beats_sent = 0;

    // Alarm setting as last written, used only to aim the stimulus at it.
    logic [4:0]            alarm_hr = '0;
    logic [5:0]            alarm_mn = '0;

    always #5 clk = ~clk;

    rtc_calendar_with_alarm_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_beat  (out_beat)
    );

    rtcal_checker u_check (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_beat   (in_beat),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_beat  (out_beat),
        .o_fails     (fails),
        .o_waiting   (waiting)
    );

    // The result side stalls at random, except during the calm phase.
    always @(posedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // Hard limit on the run: far beyond the slowest correct run.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Offers one beat, with random idle cycles first, and returns once it is taken.
    // Valid stays high on return so a following beat can go out back to back.
    task automatic push_beat(input rtcal_pkg::t_in_beat b);
        while (!calm && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_beat  <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
    endtask

    function automatic rtcal_pkg::t_in_beat random_fields();
        rtcal_pkg::t_in_beat b;
        b.cmd         = 1'($urandom);
        b.load_year   = 16'($urandom);
        b.load_month  = 4'($urandom);
        b.load_day    = 5'($urandom);
        b.load_hour   = 5'($urandom);
        b.load_minute = 6'($urandom);
        b.load_second = 6'($urandom);
        return b;
    endfunction

    // Tick beats carry random load fields, which the block has to ignore.
    task automatic tick(input int unsigned n);
        rtcal_pkg::t_in_beat b;
        repeat (n) begin
            b = random_fields();
            b.cmd = rtcal_pkg::CMD_TICK;
            push_beat(b);
        end
    endtask

    task automatic load(input logic [15:0] yr, input logic [3:0] mo, input logic [4:0] dy,
                        input logic [4:0] hr, input logic [5:0] mi, input logic [5:0] se);
        rtcal_pkg::t_in_beat b;
        b = '{cmd: rtcal_pkg::CMD_LOAD, load_year: yr, load_month: mo, load_day: dy,
              load_hour: hr, load_minute: mi, load_second: se};
        push_beat(b);
    endtask

    // Drops valid and waits until every expected result beat has come back,
    // then lets the pipeline settle before anything else happens.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (waiting != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    // Register writes go out on consecutive edges; the enable is lowered once at the end.
    task automatic write_reg(input logic [rtcal_pkg::CFG_IDX_W-1:0] idx,
                             input logic [rtcal_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // The upper bits of the enable and the unused index get random data to show
    // that neither reaches the alarm.
    task automatic set_alarm(input bit en, input logic [5:0] hr, input logic [5:0] mn);
        write_reg(rtcal_pkg::CFG_ALARM_ENABLE, {5'($urandom), en});
        write_reg(rtcal_pkg::CFG_ALARM_HOUR, hr);
        write_reg(rtcal_pkg::CFG_ALARM_MINUTE, mn);
        write_reg(CFG_UNUSED, 6'($urandom));
        cfg_we   <= 1'b0;
        alarm_hr = hr[4:0];
        alarm_mn = mn;
    endtask

    // One random sequence. Most are well-formed: a load just short of a roll-over
    // or of the alarm minute, then a random run of ticks that may cross it. The rest are loads
    // with every field fully random and plain runs of ticks.
    task automatic run_scenario();
        int unsigned         pick;
        logic [15:0]         yr;
        logic [3:0]          mo;
        rtcal_pkg::t_in_beat b;
        pick = $urandom_range(99);
        yr   = 16'($urandom);
        mo   = 4'($urandom_range(1, 12));
        if (pick < 20) begin
            // Aim at the alarm: either land on it by a load, or tick into it.
            if ($urandom_range(3) == 0)
                load(yr, mo, 5'($urandom_range(1, 28)), alarm_hr, alarm_mn, 6'd0);
            else if (alarm_mn != 0)
                load(yr, mo, 5'($urandom_range(1, 28)), alarm_hr, alarm_mn - 6'd1,
                     6'($urandom_range(57, 59)));
            else if (alarm_hr != 0)
                load(yr, mo, 5'($urandom_range(1, 28)), alarm_hr - 5'd1, 6'd59,
                     6'($urandom_range(57, 59)));
            else
                load(yr, mo, 5'($urandom_range(1, 31)), 5'd23, 6'd59,
                     6'($urandom_range(57, 59)));
            tick($urandom_range(1, 4));
        end else if (pick < 70) begin
            // Century and leap years are picked often so February gets exercised.
            case ($urandom_range(7))
                0:       yr = 16'd2000;
                1:       yr = 16'd1900;
                2:       yr = 16'd2100;
                3:       yr = 16'd2400;
                4:       yr = 16'd2024;
                5:       yr = 16'hFFFF;
                default: ;
            endcase
            case ($urandom_range(3))
                0:       mo = 4'd2;
                1:       mo = 4'd12;
                default: ;
            endcase
            load(yr, mo,
                 ($urandom_range(3) == 0) ? 5'($urandom_range(1, 31))
                                          : 5'($urandom_range(27, 31)),
                 ($urandom_range(1) == 0) ? 5'd23 : 5'($urandom_range(0, 23)),
                 ($urandom_range(1) == 0) ? 6'd59 : 6'($urandom_range(0, 59)),
                 6'($urandom_range(50, 59)));
            tick($urandom_range(1, 12));
        end else if (pick < 85) begin
            b = random_fields();
            b.cmd = rtcal_pkg::CMD_LOAD;
            push_beat(b);
            tick($urandom_range(0, 3));
        end else begin
            tick($urandom_range(1, 8));
        end
    endtask

    initial begin
        int unsigned phase_start;

        // Synchronous reset, held low from the start, then released.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // The first tick shows the time kept since reset, with the alarm off.
        tick(1);
        drain();

        // Directed part, with the alarm at 12:00.
        set_alarm(1'b1, 6'd12, 6'd0);
        // Every field at its widest: all counters roll and the year wraps to zero.
        load(16'hFFFF, 4'hF, 5'd31, 5'd31, 6'd63, 6'd63);
        tick(1);
        load(16'd0, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0);
        tick(1);
        // New year.
        load(16'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59);
        tick(1);
        // A year divisible by 400 is a leap year.
        load(16'd2000, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
        tick(1);
        load(16'd2000, 4'd2, 5'd29, 5'd23, 6'd59, 6'd59);
        tick(1);
        // A century not divisible by 400 is not.
        load(16'd1900, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
        tick(1);
        load(16'd2024, 4'd2, 5'd28, 5'd23, 6'd59, 6'd59);
        tick(1);
        // End of a 30-day month.
        load(16'd2023, 4'd4, 5'd30, 5'd23, 6'd59, 6'd59);
        tick(1);
        // Alarm on a load, then on a tick, then gone one second later.
        load(16'd2023, 4'd6, 5'd15, 5'd12, 6'd0, 6'd0);
        load(16'd2023, 4'd6, 5'd15, 5'd11, 6'd59, 6'd59);
        tick(2);
        // Month codes outside 1..12 act as 31-day months.
        load(16'd2023, 4'd0, 5'd31, 5'd23, 6'd59, 6'd59);
        tick(1);
        load(16'd2023, 4'd13, 5'd20, 5'd23, 6'd59, 6'd59);
        tick(1);
        drain();

        // Random phases, each under its own alarm setting. The first three hit the
        // extremes, including the widest values the register port can hold.
        for (int ph = 0; ph < N_PHASES; ph++) begin
            case (ph)
                0:       set_alarm(1'b1, 6'd0, 6'd0);
                1:       set_alarm(1'b1, 6'd23, 6'd59);
                2:       set_alarm(1'b1, 6'h3F, 6'h3F);
                3:       set_alarm(1'b0, 6'($urandom), 6'($urandom));
                default: set_alarm(1'b1, 6'($urandom_range(0, 23)),
                                   6'($urandom_range(0, 59)));
            endcase
            calm = (ph == CALM_PHASE);
            phase_start = beats_sent;
            while (beats_sent - phase_start < BEATS_PER_PHASE) run_scenario();
            drain();
        end

        if (fails == 0 && waiting == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
